// ----- hdl/sil_pkg.sv -----
// shared types, codes and helpers for the sorted insertion list
`timescale 1ns / 1ps
`default_nettype none

package sil_pkg;

    // default store depth
    localparam int DEPTH_DEF = 32;

    // field widths of the result transaction
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [VALUE_W-1:0] SIGN_BIT = 32'h8000_0000;

    // one result transaction from the control to the output register
    typedef struct packed {
        logic                load;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_result;

    // signed a <= signed b, compared unsigned with the sign bit flipped
    function automatic logic le_signed(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b);
        return (a ^ SIGN_BIT) <= (b ^ SIGN_BIT);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sil_ram.sv -----
// single-port-write, single-port-read store with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sil_ram #(
    parameter int DEPTH = sil_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire  [AW-1:0]                i_wr_addr,
    input  wire  [sil_pkg::VALUE_W-1:0]  i_wr_data,
    input  wire                          i_rd_en,
    input  wire  [AW-1:0]                i_rd_addr,
    output logic [sil_pkg::VALUE_W-1:0]  o_rd_data
);

    logic [sil_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [sil_pkg::VALUE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hdl/sil_ctrl.sv -----
// sequencer for insert shifting and dump reads over the store memory
`timescale 1ns / 1ps
`default_nettype none

module sil_ctrl #(
    parameter int DEPTH = sil_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input transaction
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_opcode,
    input  wire  [sil_pkg::VALUE_W-1:0]  i_value,
    // output register can take a result this cycle
    input  wire                          i_out_free,
    output sil_pkg::t_result             o_res,
    // memory ports
    output logic                         o_wr_en,
    output logic [AW-1:0]                o_wr_addr,
    output logic [sil_pkg::VALUE_W-1:0]  o_wr_data,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    input  wire  [sil_pkg::VALUE_W-1:0]  i_rd_data
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_CMP   = 3'd1;
    localparam logic [2:0] S_INS_HEAD  = 3'd2;
    localparam logic [2:0] S_DUMP_RD   = 3'd3;
    localparam logic [2:0] S_DUMP_DATA = 3'd4;
    localparam logic [2:0] S_RESP      = 3'd5;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [2:0]                        r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic [AW-1:0]                     r_idx, n_idx;
    logic [sil_pkg::VALUE_W-1:0]       r_val, n_val;
    logic [sil_pkg::STATUS_W-1:0]      r_status, n_status;

    logic                              accept;
    logic                              is_full;
    logic                              dump_last;
    logic [CW-1:0]                     count_m1;
    logic [AW+sil_pkg::POS_W-1:0]      pos_wide;
    logic [CW+sil_pkg::COUNT_W-1:0]    count_wide;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign is_full    = (r_count == FULL_COUNT);
    assign count_m1   = r_count - 1'b1;
    assign dump_last  = (r_idx == AW'(count_m1));
    assign pos_wide   = (AW + sil_pkg::POS_W)'(r_idx);
    assign count_wide = (CW + sil_pkg::COUNT_W)'(r_count);

    // next state, memory accesses and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_val     = r_val;
        n_status  = r_status;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx + 1'b1;
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx;
        o_res          = '0;
        o_res.count    = count_wide[sil_pkg::COUNT_W-1:0];
        o_res.last     = 1'b1;
        o_res.status   = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val    = i_value;
                    n_status = sil_pkg::ST_OK;
                    if (i_opcode == sil_pkg::OP_INSERT) begin
                        if (is_full) begin
                            n_status = sil_pkg::ST_FULL;
                            n_state  = S_RESP;
                        end else if (r_count == '0) begin
                            // empty store: value goes straight to the head
                            o_wr_en   = 1'b1;
                            o_wr_addr = '0;
                            o_wr_data = i_value;
                            n_count   = r_count + 1'b1;
                            n_state   = S_RESP;
                        end else begin
                            // scan down from the tail
                            o_rd_en   = 1'b1;
                            o_rd_addr = AW'(count_m1);
                            n_idx     = AW'(count_m1);
                            n_state   = S_INS_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = sil_pkg::ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            n_idx   = '0;
                            n_state = S_DUMP_RD;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                o_wr_en = 1'b1;
                if (sil_pkg::le_signed(i_rd_data, r_val)) begin
                    // slot found just above this entry
                    o_wr_data = r_val;
                    n_count   = r_count + 1'b1;
                    n_state   = S_RESP;
                end else begin
                    // move entry up one place
                    o_wr_data = i_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_idx - 1'b1;
                        n_idx     = r_idx - 1'b1;
                    end
                end
            end
            S_INS_HEAD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = r_val;
                n_count   = r_count + 1'b1;
                n_state   = S_RESP;
            end
            S_DUMP_RD: begin
                o_rd_en = 1'b1;
                n_state = S_DUMP_DATA;
            end
            S_DUMP_DATA: begin
                if (i_out_free) begin
                    o_res.load     = 1'b1;
                    o_res.value    = i_rd_data;
                    o_res.position = pos_wide[sil_pkg::POS_W-1:0];
                    o_res.last     = dump_last;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_DUMP_RD;
                    end
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
    end

endmodule

`default_nettype wire

// ----- hdl/sorted_insertion_list.sv -----
// top level of the sorted insertion list: control, store memory, output register
//
//  channel | direction | signals                                        | handshake
//  --------+-----------+------------------------------------------------+----------------------
//  in      | input     | i_opcode, i_value                              | i_in_valid/o_in_ready
//  out     | output    | o_value_out, o_position, o_count, o_last,      | o_out_valid/i_out_ready
//          |           | o_status                                       |
//
// one transaction at a time; the single memory read port sets the pace.
// insert: scans down from the tail, moving each larger entry up one place, then
// writes the value above the first entry not larger, or at the head; full insert
// or empty dump: straight to the result. dump: one read and one result per entry.
// reset is synchronous, active low; it clears the fill count and the control.
// a stalled output holds the sequencer, a waiting final result included.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insertion_list #(
    parameter int DEPTH = sil_pkg::DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_opcode,
    input  wire  signed [sil_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [sil_pkg::VALUE_W-1:0]  o_value_out,
    output logic [sil_pkg::POS_W-1:0]           o_position,
    output logic [sil_pkg::COUNT_W-1:0]         o_count,
    output logic                                o_last,
    output logic [sil_pkg::STATUS_W-1:0]        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sil_pkg::t_result                res;
    logic                            out_free;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [sil_pkg::VALUE_W-1:0]     wr_data;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [sil_pkg::VALUE_W-1:0]     rd_data;

    logic                            r_out_valid;
    logic [sil_pkg::VALUE_W-1:0]     r_value_out;
    logic [sil_pkg::POS_W-1:0]       r_position;
    logic [sil_pkg::COUNT_W-1:0]     r_count;
    logic                            r_last;
    logic [sil_pkg::STATUS_W-1:0]    r_status;

    assign out_free = !r_out_valid || i_out_ready;

    sil_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .i_out_free (out_free),
        .o_res      (res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    sil_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_value_out <= res.value;
            r_position  <= res.position;
            r_count     <= res.count;
            r_last      <= res.last;
            r_status    <= res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = $signed(r_value_out);
    assign o_position  = r_position;
    assign o_count     = r_count;
    assign o_last      = r_last;
    assign o_status    = r_status;

    // error and insert results are single, final transactions
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != sil_pkg::ST_OK) |-> o_last)
        else $error("non-ok result without last mark");

    // empty dump reports zero count, zero value and zero position
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sil_pkg::ST_EMPTY) |->
        (o_count == '0) && (o_value_out == '0) && (o_position == '0))
        else $error("empty result carries data");

    // one transaction in flight: ready drops after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while busy");

    // a dump result that is not last has more entries behind it
    a_dump_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sil_pkg::ST_OK) && !o_last |->
        (o_count != '0))
        else $error("dump result beyond fill count");

endmodule

`default_nettype wire

// ----- tb/sv/tb_sorted_insertion_list.sv -----
// self-checking testbench for the sorted insertion list with a queue-fed driver and a monitor
`timescale 1ns / 1ps

module tb_sorted_insertion_list;

    localparam int LIST_DEPTH = sil_pkg::DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 190;

    // one request to the block
    typedef struct {
        logic                        op;
        logic [sil_pkg::VALUE_W-1:0] value;
    } t_list_req;

    // one result transaction as the block should give it
    typedef struct {
        logic [sil_pkg::VALUE_W-1:0]  value;
        logic [sil_pkg::POS_W-1:0]    position;
        logic [sil_pkg::COUNT_W-1:0]  count;
        logic                         last;
        logic [sil_pkg::STATUS_W-1:0] status;
    } t_list_result;

    logic                                i_clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                opcode = sil_pkg::OP_INSERT;
    logic signed [sil_pkg::VALUE_W-1:0]  value_in = '0;
    logic                                out_ready = 1'b0;
    logic                                hold_off = 1'b0;

    wire                                 in_ready;
    wire                                 out_valid;
    wire signed [sil_pkg::VALUE_W-1:0]   value_out;
    wire [sil_pkg::POS_W-1:0]            position;
    wire [sil_pkg::COUNT_W-1:0]          count;
    wire                                 last;
    wire [sil_pkg::STATUS_W-1:0]         status;

    t_list_req                           request_q[$];
    t_list_result                        result_q[$];
    logic signed [sil_pkg::VALUE_W-1:0]  shadow_list[$];

    int error_cnt = 0;
    int accepted_cnt = 0;
    int insert_cnt = 0;
    int dropped_cnt = 0;
    int dump_cnt = 0;
    int checked_cnt = 0;
    int max_fill = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    sorted_insertion_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_opcode   (opcode),
        .i_value    (value_in),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_value_out(value_out),
        .o_position (position),
        .o_count    (count),
        .o_last     (last),
        .o_status   (status)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // update the shadow list and queue the results one transaction should give
    function automatic void predict_list_op(input logic op,
                                            input logic signed [sil_pkg::VALUE_W-1:0] v);
        t_list_result r;
        int slot;
        int n;
        n = shadow_list.size();
        r.value = '0;
        r.position = '0;
        r.last = 1'b1;
        if (op == sil_pkg::OP_INSERT) begin
            insert_cnt++;
            if (n >= LIST_DEPTH) begin
                dropped_cnt++;
                r.count = sil_pkg::COUNT_W'(LIST_DEPTH);
                r.status = sil_pkg::ST_FULL;
                result_q.push_back(r);
                return;
            end
            // equal values stay ahead of the new one
            slot = 0;
            while (slot < n && shadow_list[slot] <= v) slot++;
            shadow_list.insert(slot, v);
            if (n + 1 > max_fill) max_fill = n + 1;
            r.count = sil_pkg::COUNT_W'(n + 1);
            r.status = sil_pkg::ST_OK;
            result_q.push_back(r);
            return;
        end
        dump_cnt++;
        if (n == 0) begin
            r.count = '0;
            r.status = sil_pkg::ST_EMPTY;
            result_q.push_back(r);
            return;
        end
        for (int i = 0; i < n; i++) begin
            r.value = shadow_list[i];
            r.position = sil_pkg::POS_W'(i);
            r.count = sil_pkg::COUNT_W'(n);
            r.last = (i == n - 1);
            r.status = sil_pkg::ST_OK;
            result_q.push_back(r);
        end
    endfunction

    // compare one field of a result
    function automatic void check_field(input string name,
                                        input logic [sil_pkg::VALUE_W-1:0] e,
                                        input logic [sil_pkg::VALUE_W-1:0] a);
        if (e !== a) begin
            error_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        end
    endfunction

    // pick a value that leans toward extremes and duplicates
    function automatic logic [sil_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return sil_pkg::VALUE_W'($urandom_range(0, 16)) - sil_pkg::VALUE_W'(8);
            3: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            4:       return 32'h8000_0000 + sil_pkg::VALUE_W'($urandom_range(0, 3));
            default: return 32'h7fff_ffff - sil_pkg::VALUE_W'($urandom_range(0, 3));
        endcase
    endfunction

    // sender: bursts of transactions with random gaps, valid held until accepted
    always @(posedge i_clk) begin : sender
        t_list_req req;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_list_op(opcode, value_in);
                accepted_cnt++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0 || request_q.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    in_valid <= 1'b0;
                end else begin
                    req = request_q.pop_front();
                    in_valid <= 1'b1;
                    opcode <= req.op;
                    value_in <= req.value;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver: stall pattern switching between modes, plus the long hold-off
    always @(posedge i_clk) begin : receiver
        logic rdy;
        rdy = 1'b0;
        if (rst_n) begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(10, 80);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = (rx_mode_left % 3 != 0);
            endcase
            if (hold_off) rdy = 1'b0;
        end
        out_ready <= rdy;
    end

    // monitor: check each result transaction against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_list_result e;
        if (rst_n && out_valid && out_ready) begin
            if (result_q.size() == 0) begin
                error_cnt++;
                $display("%0t: unexpected result, expected none, actual value %0h pos %0d %s %0d",
                         $time, value_out, position, "count", count);
            end else begin
                e = result_q.pop_front();
                checked_cnt++;
                check_field("value_out", e.value, value_out);
                check_field("position", sil_pkg::VALUE_W'(e.position),
                            sil_pkg::VALUE_W'(position));
                check_field("count", sil_pkg::VALUE_W'(e.count), sil_pkg::VALUE_W'(count));
                check_field("last", sil_pkg::VALUE_W'(e.last), sil_pkg::VALUE_W'(last));
                check_field("status", sil_pkg::VALUE_W'(e.status), sil_pkg::VALUE_W'(status));
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin : hold_off_ctl
        wait (accepted_cnt >= 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // stimulus and end of run
    initial begin : stimulus
        t_list_req req;
        int gen_fill;
        logic [sil_pkg::VALUE_W-1:0] directed_vals[$];

        // directed: empty dump, extremes, duplicates, dumps in between
        req.op = sil_pkg::OP_DUMP;
        req.value = 32'hdead_beef;
        request_q.push_back(req);
        directed_vals = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                          32'h0000_0005, 32'h0000_0005, 32'hffff_fffb, 32'h0000_0001};
        foreach (directed_vals[i]) begin
            req.op = sil_pkg::OP_INSERT;
            req.value = directed_vals[i];
            request_q.push_back(req);
        end
        req.op = sil_pkg::OP_DUMP;
        req.value = 32'h0;
        request_q.push_back(req);
        req.op = sil_pkg::OP_INSERT;
        req.value = 32'h8000_0000;
        request_q.push_back(req);
        req.value = 32'h7fff_ffff;
        request_q.push_back(req);
        req.value = 32'hffff_ffff;
        request_q.push_back(req);
        req.op = sil_pkg::OP_DUMP;
        req.value = 32'hffff_ffff;
        request_q.push_back(req);
        gen_fill = 11;

        // random: inserts fill the list gradually, then full drops and full dumps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (gen_fill < LIST_DEPTH)
                req.op = ($urandom_range(0, 99) < 25) ? sil_pkg::OP_INSERT : sil_pkg::OP_DUMP;
            else
                req.op = $urandom_range(0, 1) ? sil_pkg::OP_INSERT : sil_pkg::OP_DUMP;
            req.value = pick_value();
            if (req.op == sil_pkg::OP_INSERT && gen_fill < LIST_DEPTH) gen_fill++;
            request_q.push_back(req);
        end

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_valid) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d inserts (%0d dropped on a full list) and %0d dumps",
                 insert_cnt, dropped_cnt, dump_cnt);
        $display("checked %0d result transactions, list reached %0d of %0d entries",
                 checked_cnt, max_fill, LIST_DEPTH);
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
